// File: rtl/core/tpg_pkg.sv
// Shared widths, register indexes, configuration struct and saturation helper
// for the trapezoid profile generator. No dependencies.
package tpg_pkg;

   localparam int POS_BITS      = 32;   // Q16.16 position and velocity
   localparam int TICK_BITS     = 16;   // tick counters, 8..32
   localparam int WIDE_BITS     = POS_BITS + 2;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int DIV_CNT_BITS  = $clog2(POS_BITS);

   localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(POS_BITS - 1);

   localparam logic [CSR_IDX_BITS-1:0] REG_START_POS   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_END_POS     = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_START_VEL   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_END_VEL     = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_CRUISE_VEL  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_ACCEL_TICKS = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_DECEL_TICKS = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] REG_TOTAL_TICKS = 3'd7;

   localparam logic signed [WIDE_BITS-1:0] Q_MAX = WIDE_BITS'(64'sd2147483647);
   localparam logic signed [WIDE_BITS-1:0] Q_MIN = WIDE_BITS'(-64'sd2147483648);

   typedef struct packed {
      logic signed [POS_BITS-1:0] start_position;
      logic signed [POS_BITS-1:0] end_position;
      logic signed [POS_BITS-1:0] start_velocity;
      logic signed [POS_BITS-1:0] end_velocity;
      logic signed [POS_BITS-1:0] cruise_velocity;
      logic [TICK_BITS-1:0]       accel_ticks;
      logic [TICK_BITS-1:0]       decel_ticks;
      logic [TICK_BITS-1:0]       total_ticks;
   } cfg_type;

   function automatic logic signed [POS_BITS-1:0] sat_q(input logic signed [WIDE_BITS-1:0] v);
      logic signed [POS_BITS-1:0] r;
      if (v > Q_MAX) begin
         r = Q_MAX[POS_BITS-1:0];
      end else if (v < Q_MIN) begin
         r = Q_MIN[POS_BITS-1:0];
      end else begin
         r = v[POS_BITS-1:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/core/tpg_csr.sv
// Configuration register file of the trapezoid profile generator.
// Depends on tpg_pkg.
module tpg_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [tpg_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [tpg_pkg::CSR_DATA_BITS-1:0]   csr_write_data,
   output tpg_pkg::cfg_type                    cfg
);
   import tpg_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_START_POS:   cfg_in.start_position  = csr_write_data[POS_BITS-1:0];
            REG_END_POS:     cfg_in.end_position    = csr_write_data[POS_BITS-1:0];
            REG_START_VEL:   cfg_in.start_velocity  = csr_write_data[POS_BITS-1:0];
            REG_END_VEL:     cfg_in.end_velocity    = csr_write_data[POS_BITS-1:0];
            REG_CRUISE_VEL:  cfg_in.cruise_velocity = csr_write_data[POS_BITS-1:0];
            REG_ACCEL_TICKS: cfg_in.accel_ticks     = csr_write_data[TICK_BITS-1:0];
            REG_DECEL_TICKS: cfg_in.decel_ticks     = csr_write_data[TICK_BITS-1:0];
            REG_TOTAL_TICKS: cfg_in.total_ticks     = csr_write_data[TICK_BITS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/tpg_div.sv
// Bit-serial restoring divider: signed ramp difference over an unsigned tick
// count, one quotient bit per cycle, truncating toward zero. Depends on tpg_pkg.
module tpg_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                div_start,
   input  logic signed [tpg_pkg::POS_BITS:0]   div_dividend,
   input  logic [tpg_pkg::TICK_BITS-1:0]       div_divisor,
   output logic                                div_done,
   output logic signed [tpg_pkg::POS_BITS:0]   div_quotient
);
   import tpg_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic                    neg_ff, neg_in;
   logic [POS_BITS-1:0]     mag_ff, mag_in;
   logic [TICK_BITS-1:0]    rem_ff, rem_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;

   logic signed [POS_BITS:0] abs_dividend;
   logic [TICK_BITS:0]       trial;
   logic [TICK_BITS:0]       diff;
   logic                     fits;
   logic [POS_BITS:0]        mag_ext;

   assign abs_dividend = div_dividend[POS_BITS] ? -div_dividend : div_dividend;
   // shift the next dividend bit into the partial remainder
   assign trial = {rem_ff, mag_ff[POS_BITS-1]};
   assign diff  = trial - {1'b0, div_divisor};
   assign fits  = trial >= {1'b0, div_divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (div_start) begin
         busy_in = 1'b1;
         neg_in  = div_dividend[POS_BITS];
         mag_in  = abs_dividend[POS_BITS-1:0];
         rem_in  = '0;
         cnt_in  = '0;
      end else if (busy_ff) begin
         // quotient bits fill the dividend word from the bottom
         mag_in = {mag_ff[POS_BITS-2:0], fits};
         rem_in = fits ? diff[TICK_BITS-1:0] : trial[TICK_BITS-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign mag_ext      = {1'b0, mag_ff};
   assign div_quotient = neg_ff ? -$signed(mag_ext) : $signed(mag_ext);
   assign div_done     = done_ff;

endmodule

// File: rtl/core/trapezoid_profile_generator.sv
// Single-axis trapezoidal motion profile generator, top level.
// Depends on tpg_pkg, tpg_csr and tpg_div.
//
// Usage:
//   Each word on the req_ channel is one servo tick; req_restart reloads
//   position and velocity from the start registers and clears the tick count
//   before the tick is processed. Each running tick yields one rsp_ word with
//   the new Q16.16 position; rsp_last marks the final point of the profile.
//   Ticks after the end of the profile (or a restart with zero total ticks)
//   give no word.
//   An accepted tick passes through the evaluate, divide, position and emit
//   states; the divide state waits on the bit-serial divider, one quotient
//   bit per cycle. A cruise tick or an empty ramp skips the divide state, and
//   a tick past the end returns to idle from the evaluate state. One tick is
//   processed at a time. req_ready is high only while the block is idle, and
//   it stays high while a finished word waits in the output register. If the
//   receiver stalls with a word still held, the next result waits in its
//   last stage until the output register frees up. Reset zeroes the
//   configuration, position and velocity and marks the profile finished; the
//   output word is not reset. Configuration writes also reach a tick in flight.
module trapezoid_profile_generator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [tpg_pkg::POS_BITS-1:0] rsp_position,
   output logic                                rsp_last,
   input  logic                                csr_write_enable,
   input  logic [tpg_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [tpg_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);
   import tpg_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EVAL = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_POS  = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   cfg_type cfg;

   logic [2:0]                 state_ff, state_in;
   logic signed [POS_BITS-1:0] pos_ff, pos_in;
   logic signed [POS_BITS-1:0] vel_ff, vel_in;
   logic [TICK_BITS:0]         tick_ff, tick_in;
   logic                       dir_ff, dir_in;   // 1: moving negative
   logic                       dec_ff, dec_in;   // divider serves the decel ramp
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [POS_BITS-1:0] rsp_position_ff, rsp_position_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       div_start;
   logic                       div_done;
   logic signed [POS_BITS:0]   div_dividend;
   logic signed [POS_BITS:0]   div_quotient;
   logic [TICK_BITS-1:0]       div_divisor;

   logic                       running;
   logic                       in_accel;
   logic                       in_cruise;
   logic signed [TICK_BITS+1:0] cruise_end;
   logic signed [POS_BITS:0]   ramp_target;
   logic signed [WIDE_BITS-1:0] q_wide;
   logic signed [WIDE_BITS-1:0] vel_sum;
   logic signed [POS_BITS:0]   remain;
   logic [POS_BITS:0]          abs_remain;
   logic                       beyond;
   logic signed [WIDE_BITS-1:0] vel_wide;
   logic signed [WIDE_BITS-1:0] pos_sum;
   logic                       out_free;

   tpg_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   tpg_div u_div (
      .clock        (clock),
      .reset        (reset),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

   // phase decode for the tick being evaluated
   assign running    = tick_ff < {1'b0, cfg.total_ticks};
   assign in_accel   = tick_ff < {1'b0, cfg.accel_ticks};
   assign cruise_end = $signed({2'b00, cfg.total_ticks}) - $signed({2'b00, cfg.decel_ticks});
   assign in_cruise  = $signed({1'b0, tick_ff}) < cruise_end;

   assign ramp_target  = in_accel ?
                         $signed({cfg.start_velocity[POS_BITS-1], cfg.start_velocity}) :
                         $signed({cfg.end_velocity[POS_BITS-1], cfg.end_velocity});
   assign div_dividend = $signed({cfg.cruise_velocity[POS_BITS-1], cfg.cruise_velocity})
                       - ramp_target;
   assign div_divisor  = dec_ff ? cfg.decel_ticks : cfg.accel_ticks;
   assign div_start    = (state_ff == ST_EVAL) && running &&
                         (in_accel || (!in_cruise && (cfg.decel_ticks != '0)));

   // velocity ramp step
   assign q_wide  = WIDE_BITS'(div_quotient);
   assign vel_sum = WIDE_BITS'(vel_ff) + (dec_ff ? -q_wide : q_wide);

   // position step, or land on the end point
   assign remain     = $signed({cfg.end_position[POS_BITS-1], cfg.end_position})
                     - $signed({pos_ff[POS_BITS-1], pos_ff});
   assign abs_remain = remain[POS_BITS] ? -remain : remain;
   assign beyond     = vel_ff[POS_BITS-1] || (abs_remain > {1'b0, vel_ff});
   assign vel_wide   = WIDE_BITS'(vel_ff);
   assign pos_sum    = WIDE_BITS'(pos_ff) + (dir_ff ? -vel_wide : vel_wide);

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in        = state_ff;
      pos_in          = pos_ff;
      vel_in          = vel_ff;
      tick_in         = tick_ff;
      dir_in          = dir_ff;
      dec_in          = dec_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_position_in = rsp_position_ff;
      rsp_last_in     = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_restart) begin
                  pos_in  = cfg.start_position;
                  vel_in  = cfg.start_velocity;
                  tick_in = '0;
                  dir_in  = !(cfg.end_position > cfg.start_position);
               end
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (!running) begin
               state_in = ST_IDLE;
            end else if (div_start) begin
               dec_in   = !in_accel;
               state_in = ST_DIV;
            end else begin
               if (in_cruise) begin
                  vel_in = cfg.cruise_velocity;
               end
               state_in = ST_POS;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               vel_in   = sat_q(vel_sum);
               state_in = ST_POS;
            end
         end
         ST_POS: begin
            pos_in   = beyond ? sat_q(pos_sum) : cfg.end_position;
            tick_in  = tick_ff + 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_position_in = pos_ff;
               rsp_last_in     = tick_ff == {1'b0, cfg.total_ticks};
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         vel_ff       <= '0;
         tick_ff      <= {1'b1, {TICK_BITS{1'b0}}};
         dir_ff       <= 1'b0;
         dec_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         tick_ff      <= tick_in;
         dir_ff       <= dir_in;
         dec_ff       <= dec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_position_ff <= rsp_position_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign req_ready    = state_ff == ST_IDLE;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_last     = rsp_last_ff;

   // divider finishes only while the sequencer waits on it
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider done outside of ramp wait");

   // a new output word comes only from the emit stage
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EMIT))
      else $error("output word raised outside of emit stage");

   // emit with a free output register hands off and returns to idle
   a_emit_handoff: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && out_free) |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("emit stage failed to hand off its word");

endmodule

// File: tb/tb_trapezoid_profile_generator.sv
// Testbench for trapezoid_profile_generator: directed and random servo ticks, checked
// word by word against a built-in profile predictor. Depends on tpg_pkg and the RTL.
module tb_trapezoid_profile_generator;
   timeunit 1ns;
   timeprecision 1ps;
   import tpg_pkg::*;

   localparam longint SAT_HI        = 64'sd2147483647;
   localparam longint SAT_LO        = -64'sd2147483648;
   localparam int     CYCLE_LIMIT   = 500000;
   localparam int     SETTLE_CYCLES = 50;
   localparam int     TICK_TARGET   = 550;

   typedef struct packed {
      logic signed [POS_BITS-1:0] position;
      logic                       last;
   } point_type;

   class profile_scoreboard;
      cfg_type                    regs;
      logic signed [POS_BITS-1:0] pos;
      logic signed [POS_BITS-1:0] vel;
      logic [TICK_BITS:0]         tick;
      bit                         dir_neg;
      point_type                  due_points[$];
      int                         errors;

      function new();
         regs    = '0;
         pos     = '0;
         vel     = '0;
         tick    = (TICK_BITS+1)'(1) << TICK_BITS;
         dir_neg = 1'b0;
         errors  = 0;
      endfunction

      static function longint wide(logic [POS_BITS-1:0] v);
         return longint'($signed(v));
      endfunction

      static function logic [POS_BITS-1:0] clamp(longint v);
         if (v > SAT_HI) return POS_BITS'(SAT_HI);
         if (v < SAT_LO) return POS_BITS'(SAT_LO);
         return POS_BITS'(v);
      endfunction

      function void load_reg(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            REG_START_POS:   regs.start_position  = data[POS_BITS-1:0];
            REG_END_POS:     regs.end_position    = data[POS_BITS-1:0];
            REG_START_VEL:   regs.start_velocity  = data[POS_BITS-1:0];
            REG_END_VEL:     regs.end_velocity    = data[POS_BITS-1:0];
            REG_CRUISE_VEL:  regs.cruise_velocity = data[POS_BITS-1:0];
            REG_ACCEL_TICKS: regs.accel_ticks     = data[TICK_BITS-1:0];
            REG_DECEL_TICKS: regs.decel_ticks     = data[TICK_BITS-1:0];
            REG_TOTAL_TICKS: regs.total_ticks     = data[TICK_BITS-1:0];
            default: ;
         endcase
      endfunction

      // Advances the profile by one tick; returns 1 when a word is due.
      function bit note_tick(bit restart);
         longint t, cruise_end, rem, absrem, stepv;
         point_type pt;
         if (restart) begin
            pos     = regs.start_position;
            vel     = regs.start_velocity;
            tick    = '0;
            dir_neg = !((wide(regs.end_position) - wide(regs.start_position)) > 0);
         end
         if (tick >= regs.total_ticks) return 1'b0;

         t          = longint'(tick);
         cruise_end = longint'(regs.total_ticks) - longint'(regs.decel_ticks);
         if (t < longint'(regs.accel_ticks)) begin
            if (regs.accel_ticks != 0)
               vel = clamp(wide(vel) + (wide(regs.cruise_velocity) - wide(regs.start_velocity))
                           / longint'(regs.accel_ticks));
         end else if (t < cruise_end) begin
            vel = regs.cruise_velocity;
         end else begin
            if (regs.decel_ticks != 0)
               vel = clamp(wide(vel) - (wide(regs.cruise_velocity) - wide(regs.end_velocity))
                           / longint'(regs.decel_ticks));
         end

         rem    = wide(regs.end_position) - wide(pos);
         absrem = (rem < 0) ? -rem : rem;
         if (absrem > wide(vel)) begin
            stepv = dir_neg ? -wide(vel) : wide(vel);
            pos   = clamp(wide(pos) + stepv);
         end else begin
            pos = regs.end_position;
         end

         tick        = tick + 1'b1;
         pt.position = pos;
         pt.last     = (tick == {1'b0, regs.total_ticks});
         due_points  = {due_points, pt};
         return 1'b1;
      endfunction

      task report(string what);
         errors++;
         if (errors <= 100) $display("mismatch: %s", what);
      endtask

      task check_point(logic [POS_BITS-1:0] position, logic last);
         point_type exp_pt;
         if (due_points.size() == 0) begin
            report($sformatf("word with no point due, position %h last %b", position, last));
         end else begin
            exp_pt = due_points.pop_front();
            if (position !== exp_pt.position)
               report($sformatf("position %h, expected %h", position, exp_pt.position));
            if (last !== exp_pt.last)
               report($sformatf("last %b, expected %b (position %h)", last, exp_pt.last,
                                exp_pt.position));
         end
      endtask
   endclass

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_ready;
   logic                       req_restart      = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready        = 1'b0;
   logic signed [POS_BITS-1:0] rsp_position;
   logic                       rsp_last;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_IDX_BITS-1:0]    csr_index        = '0;
   logic [CSR_DATA_BITS-1:0]   csr_write_data   = '0;

   profile_scoreboard sb = new();
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int sent_ticks    = 0;

   trapezoid_profile_generator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_position     (rsp_position),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_point(rsp_position, rsp_last);
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic send_tick(input bit restart);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
      void'(sb.note_tick(restart));
      sent_ticks++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.due_points.size() != 0) @(posedge clock);
   endtask

   // a tick past the end gives no word but may still be in flight
   task automatic settle();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(input cfg_type c, input logic [7:0] sel);
      logic [CSR_DATA_BITS-1:0] data;
      for (int i = 0; i < 8; i++) begin
         if (sel[i]) begin
            data = $urandom();   // tick registers get random upper bits
            case (CSR_IDX_BITS'(i))
               REG_START_POS:   data = c.start_position;
               REG_END_POS:     data = c.end_position;
               REG_START_VEL:   data = c.start_velocity;
               REG_END_VEL:     data = c.end_velocity;
               REG_CRUISE_VEL:  data = c.cruise_velocity;
               REG_ACCEL_TICKS: data[TICK_BITS-1:0] = c.accel_ticks;
               REG_DECEL_TICKS: data[TICK_BITS-1:0] = c.decel_ticks;
               REG_TOTAL_TICKS: data[TICK_BITS-1:0] = c.total_ticks;
               default: ;
            endcase
            csr_write_enable <= 1'b1;
            csr_index        <= CSR_IDX_BITS'(i);
            csr_write_data   <= data;
            sb.load_reg(CSR_IDX_BITS'(i), data);
            @(posedge clock);
         end
      end
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [POS_BITS-1:0] edge_value();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         4: return 32'h0000_0001;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [TICK_BITS-1:0] edge_ticks(logic [TICK_BITS-1:0] tot);
      case ($urandom_range(4))
         0: return '0;
         1: return TICK_BITS'(1);
         2: return tot;
         3: return '1;
         default: return TICK_BITS'($urandom_range(0, 20));
      endcase
   endfunction

   function automatic cfg_type random_profile();
      cfg_type     c;
      longint      span, speed;
      int unsigned kind;
      kind          = $urandom_range(9);
      c.total_ticks = TICK_BITS'($urandom_range(1, 16));
      c.accel_ticks = TICK_BITS'($urandom_range(0, c.total_ticks));
      c.decel_ticks = TICK_BITS'($urandom_range(0, c.total_ticks));
      c.start_position = $signed($urandom()) >>> 6;
      span = $urandom_range(0, 32'h0080_0000);
      if ($urandom_range(1)) span = -span;
      c.end_position = POS_BITS'(longint'($signed(c.start_position)) + span);
      speed = ((span < 0) ? -span : span) / longint'(c.total_ticks)
              + $urandom_range(0, 32'h0001_0000);
      c.cruise_velocity = POS_BITS'(speed);
      c.start_velocity  = $urandom_range(0, 32'(speed));
      c.end_velocity    = $urandom_range(0, 32'(speed));
      case (kind)
         5: begin
            // backward velocities
            c.cruise_velocity = -c.cruise_velocity;
            c.start_velocity  = $signed($urandom()) >>> 12;
         end
         6: begin
            c.accel_ticks = TICK_BITS'($urandom_range(c.total_ticks / 2, c.total_ticks + 3));
            c.decel_ticks = TICK_BITS'($urandom_range(c.total_ticks / 2, c.total_ticks + 3));
         end
         7: begin
            c.start_position  = edge_value();
            c.end_position    = edge_value();
            c.start_velocity  = edge_value();
            c.end_velocity    = edge_value();
            c.cruise_velocity = edge_value();
            c.accel_ticks     = edge_ticks(c.total_ticks);
            c.decel_ticks     = edge_ticks(c.total_ticks);
         end
         8: begin
            c.start_position  = $urandom();
            c.end_position    = $urandom();
            c.start_velocity  = $urandom();
            c.end_velocity    = $urandom();
            c.cruise_velocity = $urandom();
            c.total_ticks     = TICK_BITS'($urandom_range(1, 12));
            c.accel_ticks     = TICK_BITS'($urandom_range(0, 65535));
            c.decel_ticks     = TICK_BITS'($urandom_range(0, 65535));
         end
         9: begin
            // long profiles, only the head is ever run
            case ($urandom_range(2))
               0: c.total_ticks = '0;
               1: c.total_ticks = '1;
               default: c.total_ticks = TICK_BITS'($urandom_range(0, 65535));
            endcase
            c.accel_ticks = $urandom_range(1) ? '1 : TICK_BITS'($urandom_range(0, 65535));
            c.decel_ticks = $urandom_range(1) ? '1 : TICK_BITS'($urandom_range(0, 65535));
         end
         default: ;
      endcase
      return c;
   endfunction

   initial begin
      cfg_type    prof;
      logic [7:0] sel;
      int         budget, pause_at, ticks_left, phase;
      bit         restart;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: finished after reset, then zero total
      send_tick(1'b0);
      send_tick(1'b1);
      settle();

      // plain ramp up, cruise, ramp down, then one tick past the end
      prof = '{start_position: 32'h0000_0000, end_position: 32'h000A_0000,
               start_velocity: 32'h0, end_velocity: 32'h0, cruise_velocity: 32'h0002_0000,
               accel_ticks: 16'd3, decel_ticks: 16'd3, total_ticks: 16'd10};
      program_regs(prof, 8'hFF);
      send_tick(1'b1);
      repeat (10) send_tick(1'b0);
      settle();

      // reversed move at the range limits, overlapping ramps, saturation
      prof = '{start_position: 32'h7FFF_FFFF, end_position: 32'h8000_0000,
               start_velocity: 32'h7FFF_FFFF, end_velocity: 32'h8000_0000,
               cruise_velocity: 32'h8000_0000,
               accel_ticks: 16'd2, decel_ticks: 16'd3, total_ticks: 16'd4};
      program_regs(prof, 8'hFF);
      send_tick(1'b1);
      repeat (4) send_tick(1'b0);
      settle();

      // equal ends, no ramps, negative cruise, restart mid-profile
      prof = '{start_position: 32'h8000_0000, end_position: 32'h8000_0000,
               start_velocity: 32'h0, end_velocity: 32'h7FFF_FFFF,
               cruise_velocity: 32'hFFFF_0000,
               accel_ticks: 16'd0, decel_ticks: 16'd0, total_ticks: 16'd3};
      program_regs(prof, 8'hFF);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      settle();

      phase      = 0;
      ticks_left = 0;
      sent_ticks = 0;
      while (sent_ticks < TICK_TARGET) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 70; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 70; end
            default: begin send_idle_pct = 37; stall_pct = 37; end
         endcase
         settle();
         prof = random_profile();
         // now and then change only some registers and let the profile run on
         sel = ($urandom_range(3) == 0) ? 8'($urandom()) : 8'hFF;
         program_regs(prof, sel);
         if (sel == 8'hFF) ticks_left = 0;
         budget   = $urandom_range(25, 45);
         pause_at = $urandom_range(1, budget - 1);
         for (int k = 0; k < budget; k++) begin
            if (k == pause_at) drain();
            if (ticks_left <= 0) begin
               restart    = 1'b1;
               ticks_left = int'(sb.regs.total_ticks) + $urandom_range(0, 2);
               if (ticks_left > 40) ticks_left = 40;
            end else begin
               restart = 1'b0;
            end
            if ($urandom_range(99) < 8) restart = $urandom_range(1);
            send_tick(restart);
            ticks_left--;
         end
         phase++;
      end

      settle();
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
